// ===== rtl/frx_pkg.sv =====
// frx_pkg: shared types, constants and codes of the framed packet receiver
// used by every module under rtl; depends on nothing
package frx_pkg;

    localparam int FRAME_CAPACITY = 64;
    localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
    localparam int FILL_W         = 7;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W        = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_W      = 1;

    localparam logic [7:0]        MIN_FRAME_LENGTH = 8'd5;
    localparam logic [7:0]        MAX_FRAME_LENGTH = 8'(FRAME_CAPACITY);
    localparam logic [FILL_W-1:0] FILL_LIMIT       = FILL_W'(FRAME_CAPACITY);
    localparam logic [FILL_W-1:0] TRAILER_BYTES    = FILL_W'(2);

    localparam logic [7:0] HEADER_RESET = 8'd170;
    localparam logic [7:0] TAIL_RESET   = 8'd85;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 1'b1;

    typedef enum logic [2:0] {
        EV_ACCEPT    = 3'd0,
        EV_OUT       = 3'd1,
        EV_CSUM_DROP = 3'd2,
        EV_LEN_DROP  = 3'd3,
        EV_IGNORED   = 3'd4
    } event_t;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CHECK  = 5'b01000,
        PH_TAIL   = 5'b10000
    } phase_t;

    typedef struct packed {
        event_t            ev;
        logic [7:0]        data;
        logic [ADDR_W-1:0] pos;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] last_idx;
    } drain_cmd_t;

endpackage

// ===== rtl/frx_frame_mem.sv =====
// frx_frame_mem: frame store, one write port and one registered read port
// depends on frx_pkg
module frx_frame_mem import frx_pkg::*; (
    input  logic              aclk,
    input  mem_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] store_mem [FRAME_CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            store_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= store_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/frx_parser.sv =====
// frx_parser: frame state machine, running xor, config registers, store writes
// depends on frx_pkg
module frx_parser import frx_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    input  logic                 drain_busy,
    input  logic                 fifo_full,
    output mem_wr_t              mem_wr,
    output logic                 single_push,
    output result_t              single_res,
    output drain_cmd_t           drain_cmd
);

    logic [7:0]        header_reg, tail_reg;
    phase_t            phase_reg, phase_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] len_reg, len_next;
    logic [7:0]        xor_reg, xor_next;
    logic              acc;
    logic [FILL_W-1:0] fill_inc;
    logic              can_store;
    event_t            ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HEADER: header_reg <= cfg_wdata;
                CFG_TAIL:   tail_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign s_ready   = !drain_busy && !fifo_full;
    assign acc       = s_valid && s_ready;
    assign fill_inc  = fill_reg + FILL_W'(1);
    assign can_store = fill_reg < FILL_LIMIT;

    always_comb begin
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        xor_next       = xor_reg;
        ev             = EV_ACCEPT;
        single_push    = acc;
        mem_wr.en      = 1'b0;
        mem_wr.addr    = fill_reg[ADDR_W-1:0];
        mem_wr.data    = s_rx_byte;
        drain_cmd.start    = 1'b0;
        drain_cmd.last_idx = ADDR_W'(len_reg - FILL_W'(1));
        if (acc) begin
            unique case (phase_reg)
                PH_LENGTH: begin
                    if (s_rx_byte < MIN_FRAME_LENGTH || s_rx_byte > MAX_FRAME_LENGTH) begin
                        ev         = EV_LEN_DROP;
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                        len_next   = '0;
                        xor_next   = '0;
                    end else begin
                        len_next   = s_rx_byte[FILL_W-1:0];
                        mem_wr.en  = can_store;
                        fill_next  = fill_inc;
                        xor_next   = xor_reg ^ s_rx_byte;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    mem_wr.en = can_store;
                    fill_next = fill_inc;
                    xor_next  = xor_reg ^ s_rx_byte;
                    if (fill_inc >= len_reg - TRAILER_BYTES) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (s_rx_byte != xor_reg) begin
                        ev         = EV_CSUM_DROP;
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                        len_next   = '0;
                        xor_next   = '0;
                    end else begin
                        mem_wr.en  = can_store;
                        fill_next  = fill_inc;
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (s_rx_byte != tail_reg) begin
                        ev = EV_IGNORED;
                    end else begin
                        // tail goes into the store, then the whole frame is read out
                        mem_wr.en       = can_store;
                        single_push     = 1'b0;
                        drain_cmd.start = 1'b1;
                        phase_next      = PH_HUNT;
                        fill_next       = '0;
                        len_next        = '0;
                        xor_next        = '0;
                    end
                end
                default: begin
                    if (s_rx_byte != header_reg) begin
                        ev         = EV_IGNORED;
                        phase_next = PH_HUNT;
                    end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = '0;
                        fill_next   = FILL_W'(1);
                        len_next    = '0;
                        xor_next    = s_rx_byte;
                        phase_next  = PH_LENGTH;
                    end
                end
            endcase
        end
    end

    assign single_res.ev   = ev;
    assign single_res.data = '0;
    assign single_res.pos  = '0;
    assign single_res.last = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            fill_reg  <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
        end
    end

    a_no_accept_while_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_busy |-> !acc)
        else $error("item accepted while frame drain active");

    a_tail_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_cmd.start |=> phase_reg == PH_HUNT && fill_reg == '0)
        else $error("parser not back to hunting after frame complete");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr.en && phase_reg != PH_HUNT) |-> fill_reg < FILL_LIMIT)
        else $error("frame store write beyond capacity");

endmodule

// ===== rtl/frx_drain.sv =====
// frx_drain: read sequencer that streams a stored frame into the result queue
// depends on frx_pkg
module frx_drain import frx_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  drain_cmd_t         cmd,
    input  logic [LEVEL_W-1:0] fifo_level,
    output logic               busy,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [7:0]         rd_data,
    output logic               push,
    output result_t            res
);

    logic              busy_reg, issued_all_reg, inflight_reg, inflight_last_reg;
    logic [ADDR_W-1:0] idx_reg, last_idx_reg, inflight_pos_reg;
    logic              at_last;
    logic [LEVEL_W:0]  occupancy;

    assign at_last   = idx_reg == last_idx_reg;
    // queue entries plus the read still in flight must leave room for one more
    assign occupancy = {1'b0, fifo_level} + (LEVEL_W + 1)'(inflight_reg);
    assign rd_en     = busy_reg && !issued_all_reg && occupancy < (LEVEL_W + 1)'(FIFO_DEPTH);
    assign rd_addr   = idx_reg;
    assign busy      = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg          <= 1'b0;
            issued_all_reg    <= 1'b0;
            inflight_reg      <= 1'b0;
            inflight_last_reg <= 1'b0;
        end else begin
            inflight_reg      <= rd_en;
            inflight_last_reg <= rd_en && at_last;
            if (cmd.start) begin
                busy_reg       <= 1'b1;
                issued_all_reg <= 1'b0;
            end else begin
                if (rd_en && at_last) begin
                    issued_all_reg <= 1'b1;
                end
                if (inflight_reg && inflight_last_reg) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            idx_reg      <= '0;
            last_idx_reg <= cmd.last_idx;
        end else if (rd_en) begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (rd_en) begin
            inflight_pos_reg <= idx_reg;
        end
    end

    assign push     = inflight_reg;
    assign res.ev   = EV_OUT;
    assign res.data = rd_data;
    assign res.pos  = inflight_pos_reg;
    assign res.last = inflight_last_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("drain started while previous frame still draining");

    a_inflight_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg |-> busy_reg)
        else $error("read data returned outside a drain");

    a_no_read_past_end: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> idx_reg <= last_idx_reg)
        else $error("drain read beyond frame end");

endmodule

// ===== rtl/frx_result_fifo.sv =====
// frx_result_fifo: small result queue that decouples the m_ channel
// depends on frx_pkg
module frx_result_fifo import frx_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  result_t            push_res,
    output logic               full,
    output logic [LEVEL_W-1:0] level,
    output logic               m_valid,
    input  logic               m_ready,
    output result_t            m_res
);

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0]      count_reg;
    logic                    pop;

    assign level   = count_reg;
    assign full    = count_reg == LEVEL_W'(FIFO_DEPTH);
    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign m_res   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + LEVEL_W'(push) - LEVEL_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("result queue overflow");

    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + LEVEL_W'(1))
        else $error("result queue level lost a push");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result queue not empty after reset");

endmodule

// ===== rtl/framed_packet_receiver_xor.sv =====
// framed_packet_receiver_xor: top level of the framed byte receiver
// depends on frx_pkg, frx_parser, frx_frame_mem, frx_drain, frx_result_fifo
//
// usage
// - s_ channel: one received byte per item (s_rx_byte), valid/ready handshake
// - m_ channel: result items (event, frame byte, byte position, last)
// - cfg port: cfg_we with cfg_index 0 sets the header byte, 1 the tail byte;
//   write only while the block is idle, no read-back
// - frames are header, length L (whole frame), data, xor checksum, tail;
//   bytes that pass their checks go into a 64-entry frame store on arrival
// - a byte that is not a matching tail gives one item on m_, registered in
//   the result queue; bytes are taken one per cycle while s_ready is high
// - a matching tail starts a read-out of the store: each frame byte is read
//   from the store and registered into the result queue, one item per cycle
//   while the receiver keeps up, L items in all with last on the final one
// - s_ready stays low from the tail until the last read of that frame has
//   landed in the result queue; the store's single read port sets the pace
//   of that read-out
// - a four-entry result queue sits before m_; when the receiver stalls it
//   fills; s_ready stops when full, the drain when a read would overfill it
// - reset (aresetn low, synchronous) restores the default header and tail
//   bytes, returns to hunting and empties the queue; the store is not cleared
//   as every entry is written in a frame before it is read
module framed_packet_receiver_xor import frx_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_event_res,
    output logic [7:0]           m_frame_byte,
    output logic [5:0]           m_byte_position,
    output logic                 m_last
);

    mem_wr_t            mem_wr;
    drain_cmd_t         drain_cmd;
    result_t            single_res, drain_res, push_res, m_res;
    logic               single_push, drain_push, push;
    logic               drain_busy, fifo_full;
    logic [LEVEL_W-1:0] fifo_level;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    // byte parser: phase, running xor, length check, store writes
    frx_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .drain_busy  (drain_busy),
        .fifo_full   (fifo_full),
        .mem_wr      (mem_wr),
        .single_push (single_push),
        .single_res  (single_res),
        .drain_cmd   (drain_cmd)
    );

    // frame store; the tail write lands before the first drain read
    frx_frame_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    frx_drain u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (drain_cmd),
        .fifo_level (fifo_level),
        .busy       (drain_busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .push       (drain_push),
        .res        (drain_res)
    );

    // parser and drain never push together: inputs are held off while draining
    assign push     = single_push || drain_push;
    assign push_res = drain_push ? drain_res : single_res;

    frx_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_res (push_res),
        .full     (fifo_full),
        .level    (fifo_level),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_event_res     = m_res.ev;
    assign m_frame_byte    = m_res.data;
    assign m_byte_position = m_res.pos;
    assign m_last          = m_res.last;

    a_single_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(single_push && drain_push))
        else $error("parser and drain pushed in the same cycle");

    a_drain_follows_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_cmd.start |=> drain_busy && !s_ready)
        else $error("drain not active after frame tail");

    a_last_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_push && drain_res.last) |=> !drain_busy)
        else $error("drain still busy after last frame byte");

endmodule

// ===== dv/framed_packet_receiver_xor_test.sv =====
`timescale 1ns / 1ps
// framed_packet_receiver_xor_test: self-checking testbench for the framed byte receiver,
// with a cycle-free frame predictor, a queue-fed driver and a checking monitor
// depends on frx_pkg and framed_packet_receiver_xor
module framed_packet_receiver_xor_test;
    import frx_pkg::*;

    // a quiet stretch this long means the block has hung
    localparam int WATCHDOG_LIMIT = 2000;
    // long receiver hold-off, enough to fill the result queue and stall s_ready
    localparam int HOLD_CYCLES    = 160;
    // pause after the last result before touching the registers
    localparam int SETTLE_CYCLES  = 8;
    // tail of the run: a full 64-byte read-out plus the pipeline
    localparam int DRAIN_CYCLES   = 80;
    localparam int PRINT_LIMIT    = 50;

    // how a generated frame is spoilt
    localparam int FLAW_NONE       = 0;
    localparam int FLAW_CSUM       = 1;
    localparam int FLAW_NOISY_TAIL = 2;
    localparam int FLAW_BAD_LENGTH = 3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HEADER;
    logic [7:0]           cfg_wdata = 8'h00;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [2:0]           m_event_res;
    logic [7:0]           m_frame_byte;
    logic [5:0]           m_byte_position;
    logic                 m_last;

    framed_packet_receiver_xor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_frame_byte    (m_frame_byte),
        .m_byte_position (m_byte_position),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // frame predictor: own copy of the parser state and the two registers
    // ------------------------------------------------------------------
    phase_t            rx_phase;
    logic [FILL_W-1:0] fill_cnt;
    logic [7:0]        frame_len;
    logic [7:0]        xor_acc;
    logic [7:0]        frame_copy [FRAME_CAPACITY];
    logic [7:0]        hdr_val;
    logic [7:0]        tail_val;

    result_t    frame_results [$];   // expected result items, oldest first
    logic [7:0] byte_queue [$];      // bytes waiting for the driver

    int bytes_queued = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int ev_seen [5]  = '{default: 0};
    int mismatches   = 0;

    // knobs for the driver and the receiver: chances in percent, hold-off requests
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_asked   = 0;

    task automatic restart_hunt();
        rx_phase  = PH_HUNT;
        fill_cnt  = '0;
        frame_len = 8'h00;
        xor_acc   = 8'h00;
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (fill_cnt < FILL_LIMIT)
            frame_copy[fill_cnt[ADDR_W-1:0]] = b;
        fill_cnt = fill_cnt + 1'b1;
    endtask

    task automatic push_single(input event_t code);
        result_t r;
        r.ev   = code;
        r.data = 8'h00;
        r.pos  = '0;
        r.last = 1'b1;
        frame_results.push_back(r);
    endtask

    // works out every result item caused by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        result_t r;
        int n;
        int i;
        case (rx_phase)
            PH_LENGTH: begin
                if (b < MIN_FRAME_LENGTH || b > MAX_FRAME_LENGTH) begin
                    restart_hunt();
                    push_single(EV_LEN_DROP);
                end else begin
                    frame_len = b;
                    keep_byte(b);
                    xor_acc   = xor_acc ^ b;
                    rx_phase  = PH_DATA;
                    push_single(EV_ACCEPT);
                end
            end
            PH_DATA: begin
                keep_byte(b);
                xor_acc = xor_acc ^ b;
                if (int'(fill_cnt) >= int'(frame_len) - int'(TRAILER_BYTES))
                    rx_phase = PH_CHECK;
                push_single(EV_ACCEPT);
            end
            PH_CHECK: begin
                if (b != xor_acc) begin
                    restart_hunt();
                    push_single(EV_CSUM_DROP);
                end else begin
                    keep_byte(b);
                    rx_phase = PH_TAIL;
                    push_single(EV_ACCEPT);
                end
            end
            PH_TAIL: begin
                if (b != tail_val) begin
                    push_single(EV_IGNORED);
                end else begin
                    // matching tail: the whole stored frame comes back out
                    keep_byte(b);
                    n = (int'(frame_len) > FRAME_CAPACITY) ? FRAME_CAPACITY : int'(frame_len);
                    for (i = 0; i < n; i++) begin
                        r.ev   = EV_OUT;
                        r.data = frame_copy[i];
                        r.pos  = ADDR_W'(i);
                        r.last = (i == n - 1);
                        frame_results.push_back(r);
                    end
                    restart_hunt();
                end
            end
            default: begin
                if (b != hdr_val) begin
                    rx_phase = PH_HUNT;
                    push_single(EV_IGNORED);
                end else begin
                    restart_hunt();
                    keep_byte(b);
                    xor_acc  = b;
                    rx_phase = PH_LENGTH;
                    push_single(EV_ACCEPT);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0d ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // driver: one byte item per handshake, payload held until taken
    // ------------------------------------------------------------------
    logic s_took = 1'b0;

    always @(negedge aclk) begin : sender
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_valid   <= 1'b1;
                s_rx_byte <= byte_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off counted here on request
    int hold_left = 0;
    int hold_done = 0;

    always @(negedge aclk) begin : receiver
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_asked;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every accepted byte, checks every result item
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_t want;
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_byte(s_rx_byte);
                bytes_sent++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (frame_results.size() == 0) begin
                    report_mismatch($sformatf("result item with nothing expected (event %0d)",
                                              m_event_res));
                end else begin
                    want = frame_results.pop_front();
                    ev_seen[int'(want.ev)]++;
                    if (m_event_res !== want.ev)
                        report_mismatch($sformatf("event %0d, expected %0d",
                                                  m_event_res, want.ev));
                    if (m_frame_byte !== want.data)
                        report_mismatch($sformatf("frame byte %02h, expected %02h",
                                                  m_frame_byte, want.data));
                    if (m_byte_position !== want.pos)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  m_byte_position, want.pos));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", m_last, want.last));
                end
            end
        end
    end

    // watchdog: counts cycles with no handshake on either side
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, frame_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic put(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    // one frame built for the current header and tail, possibly spoilt
    task automatic queue_frame(input int len, input int flaw);
        logic [7:0] sum;
        logic [7:0] b;
        int k;
        put(hdr_val);
        if (flaw == FLAW_BAD_LENGTH) begin
            // below the minimum or above the capacity
            if ($urandom_range(1) == 0)
                put(8'($urandom_range(int'(MIN_FRAME_LENGTH) - 1)));
            else
                put(8'($urandom_range(255, int'(MAX_FRAME_LENGTH) + 1)));
            return;
        end
        put(8'(len));
        sum = hdr_val ^ 8'(len);
        for (k = 0; k < len - 4; k++) begin
            b   = 8'($urandom_range(255));
            sum = sum ^ b;
            put(b);
        end
        if (flaw == FLAW_CSUM) begin
            put(sum ^ 8'($urandom_range(255, 1)));
            // the tail now lands while hunting
            put(tail_val);
            return;
        end
        put(sum);
        if (flaw == FLAW_NOISY_TAIL) begin
            // stray bytes while the tail is awaited
            for (k = 0; k < int'($urandom_range(3, 1)); k++) begin
                b = 8'($urandom_range(255));
                put((b == tail_val) ? (b ^ 8'h01) : b);
            end
        end
        put(tail_val);
    endtask

    // mostly clean frames with random content, the rest broken frames and noise
    task automatic queue_traffic(input int budget);
        int goal;
        int pick;
        int len;
        int k;
        logic [7:0] b;
        goal = bytes_queued + budget;
        while (bytes_queued < goal) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(29) == 0) ? $urandom_range(FRAME_CAPACITY, 13)
                                             : $urandom_range(12, int'(MIN_FRAME_LENGTH));
            if (pick < 60)
                queue_frame(len, FLAW_NONE);
            else if (pick < 72)
                queue_frame(len, FLAW_NOISY_TAIL);
            else if (pick < 84)
                queue_frame(len, FLAW_CSUM);
            else if (pick < 92)
                queue_frame(len, FLAW_BAD_LENGTH);
            else begin
                // stray bytes while hunting
                for (k = 0; k < int'($urandom_range(3, 1)); k++) begin
                    b = 8'($urandom_range(255));
                    put((b == hdr_val) ? (b ^ 8'h01) : b);
                end
            end
        end
    endtask

    // sender stays quiet until every expected result has come back
    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_valid || frame_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEADER)
            hdr_val = val;
        else
            tail_val = val;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] same;
        hdr_val  = HEADER_RESET;
        tail_val = TAIL_RESET;
        restart_hunt();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of the registers, no idling: directed cases first
        // stray byte while hunting
        put(8'h00);
        // lengths below the minimum, above the capacity and at both byte extremes
        put(HEADER_RESET); put(MIN_FRAME_LENGTH - 8'd1);
        put(HEADER_RESET); put(8'h00);
        put(HEADER_RESET); put(MAX_FRAME_LENGTH + 8'd1);
        put(HEADER_RESET); put(8'hFF);
        // shortest frame with a bad checksum
        put(HEADER_RESET); put(MIN_FRAME_LENGTH); put(8'hFF);
        put(HEADER_RESET ^ MIN_FRAME_LENGTH ^ 8'hFF ^ 8'h01);
        // shortest good frame, a stray byte and a header while awaiting the tail
        put(HEADER_RESET); put(MIN_FRAME_LENGTH); put(8'h00);
        put(HEADER_RESET ^ MIN_FRAME_LENGTH);
        put(8'hFF); put(HEADER_RESET); put(TAIL_RESET);
        queue_traffic(35);
        wait_idle();

        // extreme register values, sender mostly idle
        write_reg(CFG_HEADER, 8'h00);
        write_reg(CFG_TAIL, 8'hFF);
        send_gap_pct = 84;
        stall_pct    = 0;
        queue_traffic(50);
        wait_idle();

        // opposite extremes, receiver mostly stalling, one full-size frame
        write_reg(CFG_HEADER, 8'hFF);
        write_reg(CFG_TAIL, 8'h00);
        send_gap_pct = 0;
        stall_pct    = 84;
        queue_frame(FRAME_CAPACITY, FLAW_NONE);
        queue_traffic(30);
        wait_idle();

        // random register values, both sides idling
        write_reg(CFG_HEADER, 8'($urandom_range(255)));
        write_reg(CFG_TAIL, 8'($urandom_range(255)));
        send_gap_pct = 36;
        stall_pct    = 36;
        queue_traffic(50);
        wait_idle();

        // header and tail share one value; receiver holds off while bytes keep
        // coming so the result queue fills and s_ready drops
        same = 8'($urandom_range(255));
        write_reg(CFG_HEADER, same);
        write_reg(CFG_TAIL, same);
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_asked++;
        queue_traffic(25);
        wait_idle();
        queue_traffic(20);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d bytes driven through five register settings, %0d result items checked",
                 bytes_sent, results_seen);
        $display("%0d frame bytes read out, %0d checksum drops, %0d length drops, %0d ignored",
                 ev_seen[EV_OUT], ev_seen[EV_CSUM_DROP], ev_seen[EV_LEN_DROP],
                 ev_seen[EV_IGNORED]);
        if (mismatches == 0 && frame_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (frame_results.size() != 0)
                $display("%0d expected result items never arrived", frame_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
